/* hdl/tali_pkg.sv */
package tali_pkg;

    // Width of the step counts carried by a request.
    localparam int STEP_W = 16;

    // Default width of the target and position counters.
    localparam int COUNT_BITS_DEF = 16;

    // Request operations.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [STEP_W-1:0] x_steps;
        logic [STEP_W-1:0] y_steps;
        logic [STEP_W-1:0] z_steps;
    } cmd_t;

    typedef struct packed {
        logic pulse_x;
        logic pulse_y;
        logic pulse_z;
        logic busy_res;
        logic finished;
    } res_t;

endpackage

/* hdl/tali_if.sv */
interface tali_cmd_if
    import tali_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [STEP_W-1:0] x_steps;
    logic [STEP_W-1:0] y_steps;
    logic [STEP_W-1:0] z_steps;

    modport source (
        output valid,
        output opcode,
        output x_steps,
        output y_steps,
        output z_steps,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  x_steps,
        input  y_steps,
        input  z_steps,
        output ready
    );
endinterface

interface tali_res_if;
    logic valid;
    logic ready;
    logic pulse_x;
    logic pulse_y;
    logic pulse_z;
    logic busy_res;
    logic finished;

    modport source (
        output valid,
        output pulse_x,
        output pulse_y,
        output pulse_z,
        output busy_res,
        output finished,
        input  ready
    );

    modport sink (
        input  valid,
        input  pulse_x,
        input  pulse_y,
        input  pulse_z,
        input  busy_res,
        input  finished,
        output ready
    );
endinterface

/* hdl/tali_core.sv */
module tali_core
    import tali_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  cmd_t cmd,
    output res_t result
);

    localparam int SUM_W = COUNT_BITS + 2;
    localparam int DEV_W = 2 * COUNT_BITS + 2;

    localparam logic [2:0] AXIS_X = 3'b001;
    localparam logic [2:0] AXIS_Y = 3'b010;
    localparam logic [2:0] AXIS_Z = 3'b100;

    logic [COUNT_BITS-1:0]   tgt_x_reg, tgt_y_reg, tgt_z_reg;
    logic [COUNT_BITS-1:0]   pos_x_reg, pos_y_reg, pos_z_reg;
    logic [SUM_W-1:0]        done_reg;
    logic [SUM_W-1:0]        total_reg;
    logic signed [DEV_W-1:0] dxy_reg, dxz_reg, dyz_reg;
    logic                    active_reg;

    logic [COUNT_BITS-1:0]   ld_x, ld_y, ld_z;
    logic [SUM_W-1:0]        ld_total;
    logic                    ld_busy;
    logic                    xy_ge, xz_ge, yz_ge;
    logic [2:0]              axis;
    logic [COUNT_BITS-1:0]   sel_pos, sel_tgt;
    logic                    at_target;
    logic [SUM_W-1:0]        done_next;
    logic                    last_step;
    logic signed [DEV_W-1:0] ext_x, ext_y, ext_z;
    logic signed [DEV_W-1:0] dxy_next, dxz_next, dyz_next;

    always_comb
    begin
        ld_x     = COUNT_BITS'(cmd.x_steps);
        ld_y     = COUNT_BITS'(cmd.y_steps);
        ld_z     = COUNT_BITS'(cmd.z_steps);
        ld_total = SUM_W'(ld_x) + SUM_W'(ld_y) + SUM_W'(ld_z);
        ld_busy  = (ld_total != '0);
    end

    // The deviations are kept as running sums, so their signs are read straight
    // from the registers rather than from products of targets and positions.
    always_comb
    begin
        xy_ge = !dxy_reg[DEV_W-1];
        xz_ge = !dxz_reg[DEV_W-1];
        yz_ge = !dyz_reg[DEV_W-1];

        if (tgt_x_reg == '0)
        begin
            axis = (yz_ge && (tgt_y_reg != '0)) ? AXIS_Y : AXIS_Z;
        end
        else if (xy_ge && xz_ge)
        begin
            axis = AXIS_X;
        end
        else if (!xz_ge)
        begin
            axis = AXIS_Z;
        end
        else
        begin
            axis = AXIS_Y;
        end
    end

    always_comb
    begin
        ext_x = DEV_W'(tgt_x_reg);
        ext_y = DEV_W'(tgt_y_reg);
        ext_z = DEV_W'(tgt_z_reg);

        case (axis)
            AXIS_X:
            begin
                sel_pos  = pos_x_reg;
                sel_tgt  = tgt_x_reg;
                dxy_next = dxy_reg - ext_y;
                dxz_next = dxz_reg - ext_z;
                dyz_next = dyz_reg;
            end
            AXIS_Y:
            begin
                sel_pos  = pos_y_reg;
                sel_tgt  = tgt_y_reg;
                dxy_next = dxy_reg + ext_x;
                dxz_next = dxz_reg;
                dyz_next = dyz_reg - ext_z;
            end
            default:
            begin
                sel_pos  = pos_z_reg;
                sel_tgt  = tgt_z_reg;
                dxy_next = dxy_reg;
                dxz_next = dxz_reg + ext_x;
                dyz_next = dyz_reg + ext_y;
            end
        endcase

        at_target = (sel_pos == sel_tgt);
        done_next = done_reg + SUM_W'(1);
        last_step = (done_next >= total_reg);
    end

    always_comb
    begin
        result = '0;
        if (cmd.opcode == OP_LOAD)
        begin
            result.busy_res = ld_busy;
            result.finished = !ld_busy;
        end
        else if (active_reg)
        begin
            if (at_target)
            begin
                result.finished = 1'b1;
            end
            else
            begin
                result.pulse_x  = axis[0];
                result.pulse_y  = axis[1];
                result.pulse_z  = axis[2];
                result.busy_res = !last_step;
                result.finished = last_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (cmd.opcode == OP_LOAD)
            begin
                active_reg <= ld_busy;
            end
            else if (active_reg && (at_target || last_step))
            begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (cmd.opcode == OP_LOAD)
            begin
                tgt_x_reg <= ld_x;
                tgt_y_reg <= ld_y;
                tgt_z_reg <= ld_z;
                total_reg <= ld_total;
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                pos_z_reg <= '0;
                done_reg  <= '0;
                dxy_reg   <= '0;
                dxz_reg   <= '0;
                dyz_reg   <= '0;
            end
            else if (active_reg && !at_target)
            begin
                if (axis[0])
                begin
                    pos_x_reg <= pos_x_reg + COUNT_BITS'(1);
                end
                if (axis[1])
                begin
                    pos_y_reg <= pos_y_reg + COUNT_BITS'(1);
                end
                if (axis[2])
                begin
                    pos_z_reg <= pos_z_reg + COUNT_BITS'(1);
                end
                done_reg <= done_next;
                dxy_reg  <= dxy_next;
                dxz_reg  <= dxz_next;
                dyz_reg  <= dyz_next;
            end
        end
    end

endmodule

/* hdl/tali_out_buf.sv */
module tali_out_buf
    import tali_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  res_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output res_t pop_data
);

    logic main_valid_reg;
    logic skid_valid_reg;
    res_t main_reg;
    res_t skid_reg;
    logic push;
    logic pop;

    // A second entry lets a request be taken while the first result is stalled.
    assign push_ready = !skid_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = main_valid_reg && pop_ready;
    assign pop_valid  = main_valid_reg;
    assign pop_data   = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || pop)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

/* hdl/three_axis_linear_step_interpolator.sv */
// Channel   Role    Payload
// cmd       sink    opcode, x_steps, y_steps, z_steps
// res       source  pulse_x, pulse_y, pulse_z, busy_res, finished
//
// Every request, load or tick, gives one result, so one step per clock is
// sustained while cmd is ready; cmd is held only while both output entries are full.
// The result is registered in the output stage's main entry, or its skid entry while res stalls, before it reaches res.
// A two-entry output stage keeps cmd ready while one result waits on res.
// Reset clears the move-active flag, so the block starts idle.
module three_axis_linear_step_interpolator
    import tali_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    tali_cmd_if.sink   cmd,
    tali_res_if.source res
);

    cmd_t cmd_data;
    res_t core_result;
    res_t out_data;
    logic buf_ready;
    logic accept;

    assign cmd_data.opcode  = cmd.opcode;
    assign cmd_data.x_steps = cmd.x_steps;
    assign cmd_data.y_steps = cmd.y_steps;
    assign cmd_data.z_steps = cmd.z_steps;

    assign cmd.ready = buf_ready;
    assign accept    = cmd.valid && buf_ready;

    tali_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (cmd_data),
        .result (core_result)
    );

    tali_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd.valid),
        .push_ready (buf_ready),
        .push_data  (core_result),
        .pop_valid  (res.valid),
        .pop_ready  (res.ready),
        .pop_data   (out_data)
    );

    assign res.pulse_x  = out_data.pulse_x;
    assign res.pulse_y  = out_data.pulse_y;
    assign res.pulse_z  = out_data.pulse_z;
    assign res.busy_res = out_data.busy_res;
    assign res.finished = out_data.finished;

endmodule

/* hdl/tali_checker.sv */
module tali_checker
(
    input logic clk,
    input logic rst_n,
    input logic cmd_ready,
    input logic res_valid,
    input logic res_ready,
    input logic pulse_x,
    input logic pulse_y,
    input logic pulse_z,
    input logic busy_res,
    input logic finished
);

    // At most one axis steps on any result.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $onehot0({pulse_x, pulse_y, pulse_z}))
    else $error("more than one step pulse in a result");

    // A move cannot be both running and ended after the same request.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(busy_res && finished))
    else $error("busy and finished both set");

    // The block only refuses requests while a result is held back on res.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> res_valid)
    else $error("request refused with no result pending");

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid
            && $stable({pulse_x, pulse_y, pulse_z, busy_res, finished})))
    else $error("stalled result changed");

endmodule

bind three_axis_linear_step_interpolator tali_checker u_tali_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .pulse_x   (res.pulse_x),
    .pulse_y   (res.pulse_y),
    .pulse_z   (res.pulse_z),
    .busy_res  (res.busy_res),
    .finished  (res.finished)
);

/* verif/tali_tb_pkg.sv */
package tali_tb_pkg;
    import tali_pkg::*;

    typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_e;

    typedef logic [COUNT_BITS_DEF-1:0]   cnt_t;
    typedef logic [COUNT_BITS_DEF+1:0]   total_t;
    typedef logic [2*COUNT_BITS_DEF-1:0] prod_t;

    class step_scoreboard;
        cnt_t   tgt_x, tgt_y, tgt_z;
        cnt_t   pos_x, pos_y, pos_z;
        total_t steps_done;
        bit     moving;
        res_t   expected_q[$];
        int     errors;
        int     accepted;

        function new();
            tgt_x = '0;
            tgt_y = '0;
            tgt_z = '0;
            pos_x = '0;
            pos_y = '0;
            pos_z = '0;
            steps_done = '0;
            moving = 1'b0;
            errors = 0;
            accepted = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        // Works out the pulse and flags of one accepted request.
        function void note_request(input cmd_t req);
            res_t   exp_res;
            axis_e  axis;
            cnt_t   cur;
            cnt_t   goal;
            total_t total;
            bit     xy_ge;
            bit     xz_ge;
            bit     yz_ge;
            accepted++;
            exp_res = '0;
            if (req.opcode == OP_LOAD)
            begin
                tgt_x = cnt_t'(req.x_steps);
                tgt_y = cnt_t'(req.y_steps);
                tgt_z = cnt_t'(req.z_steps);
                pos_x = '0;
                pos_y = '0;
                pos_z = '0;
                steps_done = '0;
                moving = (tgt_x != '0) || (tgt_y != '0) || (tgt_z != '0);
                exp_res.busy_res = moving;
                exp_res.finished = !moving;
            end
            else if (moving)
            begin
                total = total_t'(tgt_x) + total_t'(tgt_y) + total_t'(tgt_z);
                if (tgt_x == '0)
                begin
                    yz_ge = prod_t'(tgt_y) * prod_t'(pos_z) >= prod_t'(tgt_z) * prod_t'(pos_y);
                    axis = (yz_ge && tgt_y != '0) ? AXIS_Y : AXIS_Z;
                end
                else
                begin
                    xy_ge = prod_t'(tgt_x) * prod_t'(pos_y) >= prod_t'(tgt_y) * prod_t'(pos_x);
                    xz_ge = prod_t'(tgt_x) * prod_t'(pos_z) >= prod_t'(tgt_z) * prod_t'(pos_x);
                    if (xy_ge && xz_ge)
                        axis = AXIS_X;
                    else if (!xz_ge)
                        axis = AXIS_Z;
                    else
                        axis = AXIS_Y;
                end
                case (axis)
                    AXIS_X:
                    begin
                        cur = pos_x;
                        goal = tgt_x;
                    end
                    AXIS_Y:
                    begin
                        cur = pos_y;
                        goal = tgt_y;
                    end
                    default:
                    begin
                        cur = pos_z;
                        goal = tgt_z;
                    end
                endcase
                if (cur == goal)
                begin
                    // The chosen axis has nothing left, so the move stops without a pulse.
                    moving = 1'b0;
                    exp_res.finished = 1'b1;
                end
                else
                begin
                    case (axis)
                        AXIS_X:
                        begin
                            pos_x = pos_x + 1'b1;
                            exp_res.pulse_x = 1'b1;
                        end
                        AXIS_Y:
                        begin
                            pos_y = pos_y + 1'b1;
                            exp_res.pulse_y = 1'b1;
                        end
                        default:
                        begin
                            pos_z = pos_z + 1'b1;
                            exp_res.pulse_z = 1'b1;
                        end
                    endcase
                    steps_done = steps_done + 1'b1;
                    if (steps_done >= total)
                    begin
                        moving = 1'b0;
                        exp_res.finished = 1'b1;
                    end
                    else
                    begin
                        exp_res.busy_res = 1'b1;
                    end
                end
            end
            expected_q.push_back(exp_res);
        endfunction

        task compare_bit(input string field, input logic got, input logic want);
            if (got !== want)
                report_mismatch($sformatf("%s got %b expected %b", field, got, want));
        endtask

        task check_result(input res_t got);
            res_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result arrived with no request outstanding");
                return;
            end
            want = expected_q.pop_front();
            compare_bit("pulse_x", got.pulse_x, want.pulse_x);
            compare_bit("pulse_y", got.pulse_y, want.pulse_y);
            compare_bit("pulse_z", got.pulse_z, want.pulse_z);
            compare_bit("busy_res", got.busy_res, want.busy_res);
            compare_bit("finished", got.finished, want.finished);
        endtask
    endclass

endpackage

/* verif/testbench.sv */
module testbench;
    import tali_pkg::*;
    import tali_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQUEST_TARGET = 1700;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 8;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

    logic clk = 1'b0;
    logic rst_n;

    tali_cmd_if cmd_ch ();
    tali_res_if res_ch ();

    three_axis_linear_step_interpolator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    step_scoreboard sb = new();

    int sent_count = 0;
    int burst_left = 0;
    int cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[three_axis_linear_step_interpolator] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        res_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.pulse_x  = res_ch.pulse_x;
            got.pulse_y  = res_ch.pulse_y;
            got.pulse_z  = res_ch.pulse_z;
            got.busy_res = res_ch.busy_res;
            got.finished = res_ch.finished;
            sb.check_result(got);
        end
    end

    // The receiver changes its stall pattern now and then, and once holds off long
    // enough for the output stage to fill and stall cmd.
    initial
    begin : receiver
        rx_mode_e mode;
        int       mode_left;
        int       hold_left;
        int       phase;
        bit       pressure_done;
        mode = RX_ALWAYS;
        mode_left = 100;
        hold_left = 0;
        phase = 0;
        pressure_done = 1'b0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!pressure_done && sb.accepted >= 600)
            begin
                pressure_done = 1'b1;
                hold_left = 400;
            end
            if (mode_left == 0)
            begin
                mode = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_ALWAYS: res_ch.ready <= 1'b1;
                    RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: res_ch.ready <= (phase % 3 == 0);
                    default:   res_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task send_request(input cmd_t req);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 20);
            gap = $urandom_range(0, 6);
            repeat (gap)
            begin
                @(negedge clk);
                cmd_ch.valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.opcode  <= req.opcode;
        cmd_ch.x_steps <= req.x_steps;
        cmd_ch.y_steps <= req.y_steps;
        cmd_ch.z_steps <= req.z_steps;
        forever
        begin
            @(posedge clk);
            if (cmd_ch.ready)
                break;
        end
        sb.note_request(req);
        sent_count++;
    endtask

    task send_load(input logic [STEP_W-1:0] x, input logic [STEP_W-1:0] y,
                   input logic [STEP_W-1:0] z);
        cmd_t req;
        req.opcode  = OP_LOAD;
        req.x_steps = x;
        req.y_steps = y;
        req.z_steps = z;
        send_request(req);
    endtask

    // A tick ignores its counts, so they carry random bits.
    task send_tick();
        cmd_t req;
        req.opcode  = OP_TICK;
        req.x_steps = STEP_W'($urandom);
        req.y_steps = STEP_W'($urandom);
        req.z_steps = STEP_W'($urandom);
        send_request(req);
    endtask

    task run_move(input logic [STEP_W-1:0] x, input logic [STEP_W-1:0] y,
                  input logic [STEP_W-1:0] z, input int ticks);
        send_load(x, y, z);
        repeat (ticks) send_tick();
    endtask

    function logic [STEP_W-1:0] small_count(input int lim);
        if ($urandom_range(0, 3) == 0)
            return '0;
        return STEP_W'($urandom_range(1, lim));
    endfunction

    initial
    begin : stimulus
        cmd_t                noise;
        logic [STEP_W-1:0]   cx, cy, cz;
        int                  lim;
        int                  total;
        int                  kind;
        rst_n = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.opcode  = OP_LOAD;
        cmd_ch.x_steps = '0;
        cmd_ch.y_steps = '0;
        cmd_ch.z_steps = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: idle tick, empty load, full-scale counts, a move replaced
        // mid-way, moves with X or Y and X empty, and single-axis moves.
        send_tick();
        send_load('0, '0, '0);
        send_tick();
        run_move(16'hFFFF, 16'hFFFF, 16'hFFFF, 3);
        run_move(16'h0000, 16'h0000, 16'hFFFF, 2);
        run_move(16'd2, 16'd1, 16'd1, 4);
        run_move(16'd0, 16'd2, 16'd1, 3);
        run_move(16'd0, 16'd0, 16'd1, 2);
        run_move(16'hFFFF, 16'h0000, 16'h0000, 1);
        run_move(16'd1, 16'd3, 16'd2, 7);

        while (sent_count < REQUEST_TARGET)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6 || kind == 9)
            begin
                lim = ($urandom_range(0, 3) == 0) ? 40 : 10;
                cx = small_count(lim);
                cy = small_count(lim);
                cz = small_count(lim);
                total = int'(cx) + int'(cy) + int'(cz);
                if (kind == 9)
                    run_move(cx, cy, cz, $urandom_range(0, total));
                else
                    run_move(cx, cy, cz, total + $urandom_range(0, 2));
            end
            else if (kind == 7)
            begin
                run_move(STEP_W'($urandom), STEP_W'($urandom), STEP_W'($urandom),
                         $urandom_range(1, 30));
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                begin
                    noise.opcode  = 1'($urandom_range(0, 1));
                    noise.x_steps = STEP_W'($urandom_range(0, 15));
                    noise.y_steps = STEP_W'($urandom_range(0, 15));
                    noise.z_steps = STEP_W'($urandom_range(0, 15));
                    send_request(noise);
                end
            end
        end

        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("[three_axis_linear_step_interpolator] OK");
        else
            $display("[three_axis_linear_step_interpolator] ERROR");
        $finish;
    end

endmodule
